/* rtl/penalty_aware_path_selector_top_macros.svh */
// assertion macros for the path selector checker
// expects clk_i and rst_ni in the scope where the macros are used
`ifndef PENALTY_AWARE_PATH_SELECTOR_TOP_MACROS_SVH
`define PENALTY_AWARE_PATH_SELECTOR_TOP_MACROS_SVH

// checked only outside reset
`define PAP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define PAP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/pap_pkg.sv */
// shared widths, codes and helpers of the penalty aware path selector
// no dependencies
package pap_pkg;

  localparam int unsigned MaxPathsDef = 256;
  localparam int unsigned PathW       = 8;
  localparam int unsigned PenW        = 8;
  localparam int unsigned EntW        = 16;
  localparam int unsigned BitsW       = 4;
  localparam int unsigned RotW        = 9;
  localparam int unsigned KindW       = 2;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 16;

  localparam logic [BitsW-1:0] PathBitsRst = 4'd8;
  localparam logic [PenW-1:0]  MaxPenRst   = 8'd15;
  localparam logic [EntW-1:0]  UpperRst    = 16'd0;

  localparam logic [PenW-1:0] AddEcn  = 8'd1;
  localparam logic [PenW-1:0] AddNack = 8'd4;

  typedef enum logic {
    FUNC_FEEDBACK = 1'b0,
    FUNC_REQUEST  = 1'b1
  } func_e;

  typedef enum logic [KindW-1:0] {
    FB_GOOD    = 2'd0,
    FB_ECN     = 2'd1,
    FB_NACK    = 2'd2,
    FB_TIMEOUT = 2'd3
  } fb_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PATH_BITS = 2'd0,
    CFG_MAX_PEN   = 2'd1,
    CFG_UPPER     = 2'd2
  } cfg_reg_e;

  // path mask from the path_bits register, clamped to 1..8
  function automatic logic [PathW-1:0] path_mask(logic [BitsW-1:0] bits);
    logic [BitsW-1:0] b;
    logic [PathW:0]   n;
    b = bits;
    if (b < 4'd1) b = 4'd1;
    if (b > 4'd8) b = 4'd8;
    n = (PathW+1)'(1) << b;
    return PathW'(n - (PathW+1)'(1));
  endfunction

endpackage

/* rtl/pap_if.sv */
// valid/ready channel interfaces of the path selector: input, result, config
// depends on pap_pkg
interface pap_in_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [pap_pkg::PathW-1:0]    path_id;
  logic [pap_pkg::KindW-1:0]    feedback_kind;
  logic [pap_pkg::PathW-1:0]    alt_random;
  logic [pap_pkg::PathW-1:0]    xor_random;

  modport source(output valid, func, path_id, feedback_kind, alt_random, xor_random,
                 input ready);
  modport sink(input valid, func, path_id, feedback_kind, alt_random, xor_random,
               output ready);
endinterface

interface pap_out_if;
  logic                      valid;
  logic                      ready;
  logic [pap_pkg::EntW-1:0]  entropy;
  logic [pap_pkg::PathW-1:0] chosen_path;

  modport source(output valid, entropy, chosen_path, input ready);
  modport sink(input valid, entropy, chosen_path, output ready);
endinterface

interface pap_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [pap_pkg::CfgIdxW-1:0]  index;
  logic [pap_pkg::CfgDataW-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* rtl/penalty_aware_path_selector_top.sv */
// Penalty aware path selector. One input beat (feedback or request) can be taken every
// cycle; a request's result is loaded from the stage two registers into an output register
// and waits there until taken, while the next beats keep flowing until a second request is
// waiting behind it. The penalty table is a RAM of min(MaxPaths, 256) entries read at two
// addresses with registered data: stage one forms the addresses and updates the rotation,
// stage two reads the penalties (with forwarding of the write made in the same cycle as the
// read), writes feedback back and picks the path. Each table entry has a valid bit, so there
// is no clearing pass after reset. Configuration writes are always accepted.
// depends on pap_pkg, pap_if, pap_ram
module penalty_aware_path_selector_top #(
  parameter int unsigned MaxPaths = pap_pkg::MaxPathsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pap_cfg_if.sink   cfg_i,
  pap_in_if.sink    in_i,
  pap_out_if.source out_o
);

  localparam int unsigned TblDepth = (MaxPaths < 256) ? MaxPaths : 256;
  localparam int unsigned TblAw    = $clog2(TblDepth);

  localparam int unsigned PathW = pap_pkg::PathW;
  localparam int unsigned PenW  = pap_pkg::PenW;
  localparam int unsigned EntW  = pap_pkg::EntW;
  localparam int unsigned RotW  = pap_pkg::RotW;

  // configuration
  logic [pap_pkg::BitsW-1:0] path_bits_q;
  logic [PenW-1:0]           max_pen_q;
  logic [EntW-1:0]           upper_q;
  logic                      cfg_fire;
  logic [PathW-1:0]          mask;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign mask        = pap_pkg::path_mask(path_bits_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      path_bits_q <= pap_pkg::PathBitsRst;
      max_pen_q   <= pap_pkg::MaxPenRst;
      upper_q     <= pap_pkg::UpperRst;
    end else if (cfg_fire) begin
      unique case (pap_pkg::cfg_reg_e'(cfg_i.index))
        pap_pkg::CFG_PATH_BITS: path_bits_q <= cfg_i.data[pap_pkg::BitsW-1:0];
        pap_pkg::CFG_MAX_PEN:   max_pen_q   <= cfg_i.data[PenW-1:0];
        pap_pkg::CFG_UPPER:     upper_q     <= cfg_i.data[EntW-1:0];
        default: ;
      endcase
    end
  end

  // stage one: addresses and rotation
  logic             in_fire;
  logic             in_req;
  logic [RotW-1:0]  rot_q;
  logic [RotW-1:0]  rot_inc;
  logic             rot_wrap;
  logic [PathW-1:0] xor_q;
  logic [PathW-1:0] rot_path;
  logic [PathW-1:0] addr_a;
  logic [PathW-1:0] addr_b;

  assign in_fire  = in_i.valid && in_i.ready;
  assign in_req   = (pap_pkg::func_e'(in_i.func) == pap_pkg::FUNC_REQUEST);
  assign rot_inc  = rot_q + RotW'(1);
  assign rot_wrap = rot_inc > {1'b0, mask};
  assign rot_path = (rot_q[PathW-1:0] ^ xor_q) & mask;
  assign addr_a   = in_req ? rot_path : (in_i.path_id & mask);
  assign addr_b   = in_i.alt_random & mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q <= '0;
      xor_q <= '0;
    end else if (in_fire && in_req) begin
      if (rot_wrap) begin
        rot_q <= '0;
        xor_q <= in_i.xor_random & mask;
      end else begin
        rot_q <= rot_inc;
      end
    end
  end

  // stage two registers
  logic                      s1_valid_q;
  logic                      s1_req_q;
  logic [pap_pkg::KindW-1:0] s1_kind_q;
  logic [PathW-1:0]          s1_addr_a_q;
  logic [PathW-1:0]          s1_addr_b_q;
  logic                      s1_adv;
  logic                      out_valid_q;
  logic                      out_load;

  assign s1_adv     = s1_valid_q && (!s1_req_q || !out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign out_load   = s1_valid_q && s1_req_q && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_req_q    <= in_req;
      s1_kind_q   <= in_i.feedback_kind;
      s1_addr_a_q <= addr_a;
      s1_addr_b_q <= addr_b;
    end
  end

  // penalty table
  logic                  wr_en;
  logic [PenW-1:0]       wr_data;
  logic [PenW-1:0]       ram_a;
  logic [PenW-1:0]       ram_b;
  logic [TblDepth-1:0]   vld_q;
  logic                  fwd_valid_q;
  logic [PathW-1:0]      fwd_addr_q;
  logic [PenW-1:0]       fwd_data_q;
  logic                  in_rng_a;
  logic                  in_rng_b;
  logic [PenW-1:0]       pen_a;
  logic [PenW-1:0]       pen_b;

  pap_ram #(
    .Width(PenW),
    .Depth(TblDepth)
  ) u_pap_ram (
    .clk_i    (clk_i),
    .we_i     (wr_en),
    .waddr_i  (s1_addr_a_q[TblAw-1:0]),
    .wdata_i  (wr_data),
    .re_i     (in_fire),
    .raddr_a_i(addr_a[TblAw-1:0]),
    .raddr_b_i(addr_b[TblAw-1:0]),
    .rdata_a_o(ram_a),
    .rdata_b_o(ram_b)
  );

  assign in_rng_a = {24'd0, s1_addr_a_q} < 32'(TblDepth);
  assign in_rng_b = {24'd0, s1_addr_b_q} < 32'(TblDepth);

  always_comb begin
    pen_a = '0;
    pen_b = '0;
    if (in_rng_a) begin
      if (fwd_valid_q && (fwd_addr_q == s1_addr_a_q)) begin
        pen_a = fwd_data_q;
      end else if (vld_q[s1_addr_a_q[TblAw-1:0]]) begin
        pen_a = ram_a;
      end
    end
    if (in_rng_b) begin
      if (fwd_valid_q && (fwd_addr_q == s1_addr_b_q)) begin
        pen_b = fwd_data_q;
      end else if (vld_q[s1_addr_b_q[TblAw-1:0]]) begin
        pen_b = ram_b;
      end
    end
  end

  // feedback update
  logic [PenW-1:0] add;
  logic [PenW:0]   sum;

  always_comb begin
    case (pap_pkg::fb_kind_e'(s1_kind_q))
      pap_pkg::FB_ECN:  add = pap_pkg::AddEcn;
      pap_pkg::FB_NACK: add = pap_pkg::AddNack;
      default:          add = max_pen_q;
    endcase
    sum = {1'b0, pen_a} + {1'b0, add};
    if (pap_pkg::fb_kind_e'(s1_kind_q) == pap_pkg::FB_GOOD) begin
      wr_data = (pen_a == '0) ? '0 : pen_a - PenW'(1);
    end else if (sum > {1'b0, max_pen_q}) begin
      wr_data = max_pen_q;
    end else begin
      wr_data = sum[PenW-1:0];
    end
  end

  assign wr_en = s1_valid_q && !s1_req_q && in_rng_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      fwd_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[s1_addr_a_q[TblAw-1:0]] <= 1'b1;
      end
      if (in_fire) begin
        fwd_valid_q <= wr_en;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      fwd_addr_q <= s1_addr_a_q;
      fwd_data_q <= wr_data;
    end
  end

  // path choice and result register
  logic             take_alt;
  logic [PathW-1:0] res;
  logic [EntW-1:0]  entropy_q;
  logic [PathW-1:0] chosen_q;

  assign take_alt = (pen_a != '0) && (pen_b < pen_a);
  assign res      = take_alt ? s1_addr_b_q : s1_addr_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      entropy_q <= {8'd0, res} | (upper_q & ~{8'd0, mask});
      chosen_q  <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.entropy     = entropy_q;
  assign out_o.chosen_path = chosen_q;

endmodule

/* rtl/pap_ram.sv */
// generic ram: one write port, two read ports, registered read data
// no dependencies
module pap_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  parameter int unsigned Aw    = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_a_i,
  input  logic [Aw-1:0]    raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

/* rtl/pap_chk.sv */
// port level checker of the path selector, bound to the top level
// depends on pap_pkg and penalty_aware_path_selector_top_macros.svh
`include "penalty_aware_path_selector_top_macros.svh"

module pap_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      in_func_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [pap_pkg::EntW-1:0]  out_entropy_i,
  input logic [pap_pkg::PathW-1:0] out_chosen_i
);

  logic in_req_beat;

  assign in_req_beat = in_valid_i && in_ready_i &&
                       (pap_pkg::func_e'(in_func_i) == pap_pkg::FUNC_REQUEST);

  `PAP_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !out_valid_i, "result valid in reset")

  `PAP_ASSERT(a_result_held, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_entropy_i) && $stable(out_chosen_i), "stalled result changed")

  `PAP_ASSERT(a_entropy_has_path, out_valid_i |-> ((out_entropy_i[pap_pkg::PathW-1:0] & out_chosen_i) == out_chosen_i), "entropy lost path bits")

  `PAP_ASSERT(a_result_from_request, $rose(out_valid_i) |-> $past(in_req_beat, 2), "result without request")

endmodule

bind penalty_aware_path_selector_top pap_chk u_pap_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_func_i    (in_i.func),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_entropy_i(out_o.entropy),
  .out_chosen_i (out_o.chosen_path)
);

/* bench/penalty_aware_path_selector_top_tb.sv */
// testbench of the penalty aware path selector: directed table, then random feedback and
// request beats over many register settings, checked against a behavioral copy of the block
// depends on pap_pkg, pap_if and the rtl of penalty_aware_path_selector_top
`timescale 1ns / 100ps

module penalty_aware_path_selector_top_tb;

  typedef struct packed {
    pap_pkg::func_e    func;
    logic [7:0]        path_id;
    pap_pkg::fb_kind_e kind;
    logic [7:0]        alt;
    logic [7:0]        xorv;
  } path_beat_t;

  typedef struct packed {
    logic [15:0] entropy;
    logic [7:0]  chosen_path;
  } route_t;

  typedef struct packed {
    path_beat_t  beat;
    logic        typed;
    route_t      route;
  } dir_row_t;

  localparam int NumPhases    = 9;
  localparam int PhaseBeats   = 180;
  localparam int HoldCycles   = 100;
  localparam int SettleCycles = 4;

  logic clk_i;
  logic rst_ni;

  pap_in_if  in_bus ();
  pap_out_if out_bus ();
  pap_cfg_if cfg_bus ();

  penalty_aware_path_selector_top u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_bus),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  // behavioral copy of the selector
  logic [7:0]  path_penalty [256];
  logic [8:0]  sel_rotate;
  logic [7:0]  sel_perm;
  logic [3:0]  cfg_path_bits;
  logic [7:0]  cfg_max_pen;
  logic [15:0] cfg_upper;

  route_t route_q [$];

  logic        tag_typed;
  route_t      tag_route;

  int tx_idle_pct;
  int rx_idle_pct;
  bit hold_rx;
  int err_cnt;
  int n_fb, n_req, n_checked, n_alt, n_wrap;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic flag_error(input string msg);
    err_cnt++;
    $display("tb: mismatch: %s", msg);
  endtask

  task automatic select_path(input path_beat_t b, output bit has_res, output route_t r);
    logic [3:0] bits;
    logic [8:0] npaths;
    logic [7:0] mask;
    logic [7:0] pid;
    logic [7:0] alt;
    logic [7:0] pick;
    logic [8:0] sum;
    logic [8:0] nxt;
    bits = cfg_path_bits;
    if (bits < 4'd1) bits = 4'd1;
    if (bits > 4'd8) bits = 4'd8;
    npaths = 9'd1 << bits;
    mask = 8'(npaths - 9'd1);
    has_res = 1'b0;
    r = '0;
    if (b.func == pap_pkg::FUNC_FEEDBACK) begin
      pid = b.path_id & mask;
      if (b.kind == pap_pkg::FB_GOOD) begin
        if (path_penalty[pid] != 8'd0) path_penalty[pid] = path_penalty[pid] - 8'd1;
      end else begin
        if (b.kind == pap_pkg::FB_ECN)
          sum = {1'b0, path_penalty[pid]} + {1'b0, pap_pkg::AddEcn};
        else if (b.kind == pap_pkg::FB_NACK)
          sum = {1'b0, path_penalty[pid]} + {1'b0, pap_pkg::AddNack};
        else sum = {1'b0, path_penalty[pid]} + {1'b0, cfg_max_pen};
        if (sum > {1'b0, cfg_max_pen}) sum = {1'b0, cfg_max_pen};
        path_penalty[pid] = sum[7:0];
      end
    end else begin
      pick = (sel_rotate[7:0] ^ sel_perm) & mask;
      nxt = sel_rotate + 9'd1;
      if (nxt >= npaths) begin
        nxt = 9'd0;
        sel_perm = b.xorv & mask;
        n_wrap++;
      end
      sel_rotate = nxt;
      if (path_penalty[pick] != 8'd0) begin
        alt = b.alt & mask;
        if (path_penalty[alt] < path_penalty[pick]) begin
          pick = alt;
          n_alt++;
        end
      end
      has_res = 1'b1;
      r.chosen_path = pick;
      r.entropy = {8'h00, pick} | (cfg_upper & ~{8'h00, mask});
    end
  endtask

  // input beats
  always @(posedge clk_i) begin
    bit     has_res;
    route_t r;
    if (rst_ni && in_bus.valid && in_bus.ready) begin
      select_path('{pap_pkg::func_e'(in_bus.func), in_bus.path_id,
                    pap_pkg::fb_kind_e'(in_bus.feedback_kind),
                    in_bus.alt_random, in_bus.xor_random}, has_res, r);
      if (in_bus.func == pap_pkg::FUNC_FEEDBACK) n_fb++;
      else n_req++;
      if (has_res) route_q.push_back(tag_typed ? tag_route : r);
    end
  end

  // result beats
  always @(posedge clk_i) begin
    route_t e;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (route_q.size() == 0) begin
        flag_error($sformatf("unexpected result entropy %h path %0d",
                             out_bus.entropy, out_bus.chosen_path));
      end else begin
        e = route_q.pop_front();
        n_checked++;
        if (out_bus.entropy !== e.entropy)
          flag_error($sformatf("entropy %h, expected %h", out_bus.entropy, e.entropy));
        if (out_bus.chosen_path !== e.chosen_path)
          flag_error($sformatf("chosen_path %0d, expected %0d",
                               out_bus.chosen_path, e.chosen_path));
      end
    end
  end

  // register writes
  always @(posedge clk_i) begin
    if (rst_ni && cfg_bus.valid && cfg_bus.ready) begin
      case (pap_pkg::cfg_reg_e'(cfg_bus.index))
        pap_pkg::CFG_PATH_BITS: cfg_path_bits = cfg_bus.data[3:0];
        pap_pkg::CFG_MAX_PEN:   cfg_max_pen = cfg_bus.data[7:0];
        pap_pkg::CFG_UPPER:     cfg_upper = cfg_bus.data;
        default: ;
      endcase
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_rx) begin
        out_bus.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_rx = 1'b0;
      end
      out_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_beat(input path_beat_t b, input logic typed, input route_t r);
    in_bus.valid         <= 1'b1;
    in_bus.func          <= b.func;
    in_bus.path_id       <= b.path_id;
    in_bus.feedback_kind <= b.kind;
    in_bus.alt_random    <= b.alt;
    in_bus.xor_random    <= b.xorv;
    tag_typed            <= typed;
    tag_route            <= r;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_bus.valid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task automatic write_reg(input pap_pkg::cfg_reg_e idx, input logic [15:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (route_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic dir_row_t fb_row(input logic [7:0] p, input pap_pkg::fb_kind_e k);
    dir_row_t row;
    row.beat  = '{pap_pkg::FUNC_FEEDBACK, p, k, 8'h00, 8'h00};
    row.typed = 1'b0;
    row.route = '0;
    return row;
  endfunction

  function automatic dir_row_t rq_row(input logic [7:0] alt, input logic [7:0] xorv,
                                      input logic typed, input logic [7:0] pth);
    dir_row_t row;
    row.beat  = '{pap_pkg::FUNC_REQUEST, 8'h00, pap_pkg::FB_GOOD, alt, xorv};
    row.typed = typed;
    row.route = '{{8'h00, pth}, pth};
    return row;
  endfunction

  function automatic path_beat_t rand_beat();
    path_beat_t b;
    int k;
    k = $urandom_range(9);
    b.func    = pap_pkg::func_e'($urandom_range(1));
    b.path_id = 8'($urandom);
    if (k < 4) b.kind = pap_pkg::FB_GOOD;
    else if (k < 6) b.kind = pap_pkg::FB_ECN;
    else if (k < 8) b.kind = pap_pkg::FB_NACK;
    else b.kind = pap_pkg::FB_TIMEOUT;
    b.alt  = 8'($urandom);
    b.xorv = 8'($urandom);
    return b;
  endfunction

  int          ph_bits [NumPhases] = '{1, 3, 0, 15, 8, 2, 9, 4, 5};
  int          ph_pen  [NumPhases] = '{255, 1, 7, 255, 3, 200, 1, 15, 2};
  logic [15:0] ph_up   [NumPhases] = '{16'hFFFF, 16'hA5A5, 16'h1234, 16'hFF00, 16'h0000,
                                       16'h0000, 16'h8001, 16'h00F0, 16'h7FFF};

  initial begin
    dir_row_t dir_rows [$];
    logic [15:0] up;
    clk_i = 1'b0;
    rst_ni = 1'b1;
    in_bus.valid = 1'b0;
    in_bus.func = pap_pkg::FUNC_FEEDBACK;
    in_bus.path_id = '0;
    in_bus.feedback_kind = pap_pkg::FB_GOOD;
    in_bus.alt_random = '0;
    in_bus.xor_random = '0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = pap_pkg::CFG_PATH_BITS;
    cfg_bus.data = '0;
    tag_typed = 1'b0;
    tag_route = '0;
    hold_rx = 1'b0;
    err_cnt = 0;
    tx_idle_pct = 8;
    rx_idle_pct = 58;
    foreach (path_penalty[j]) path_penalty[j] = 8'd0;
    sel_rotate = '0;
    sel_perm = '0;
    cfg_path_bits = pap_pkg::PathBitsRst;
    cfg_max_pen = pap_pkg::MaxPenRst;
    cfg_upper = pap_pkg::UpperRst;

    // after reset: 256 paths, ceiling 15, no upper bits
    dir_rows = '{
      rq_row(8'h00, 8'h00, 1'b1, 8'd0),
      fb_row(8'd1, pap_pkg::FB_TIMEOUT),
      rq_row(8'h02, 8'h00, 1'b1, 8'd2),
      fb_row(8'd255, pap_pkg::FB_NACK),
      fb_row(8'd255, pap_pkg::FB_ECN),
      fb_row(8'd255, pap_pkg::FB_GOOD),
      fb_row(8'd0, pap_pkg::FB_GOOD),
      fb_row(8'd1, pap_pkg::FB_ECN),
      fb_row(8'd1, pap_pkg::FB_NACK),
      rq_row(8'h01, 8'h00, 1'b1, 8'd2),
      rq_row(8'hFF, 8'hFF, 1'b1, 8'd3),
      fb_row(8'd4, pap_pkg::FB_NACK),
      rq_row(8'h01, 8'h00, 1'b1, 8'd4),
      fb_row(8'd5, pap_pkg::FB_NACK),
      rq_row(8'h04, 8'h00, 1'b1, 8'd5),
      fb_row(8'd6, pap_pkg::FB_TIMEOUT),
      fb_row(8'd6, pap_pkg::FB_GOOD),
      rq_row(8'hFF, 8'h00, 1'b0, 8'd0),
      rq_row(8'h06, 8'h00, 1'b0, 8'd0),
      fb_row(8'd255, pap_pkg::FB_TIMEOUT),
      rq_row(8'h00, 8'hFF, 1'b0, 8'd0)
    };

    #1 rst_ni = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[j]) send_beat(dir_rows[j].beat, dir_rows[j].typed, dir_rows[j].route);
    in_bus.valid <= 1'b0;

    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_drained();
      up = (ph == 5) ? 16'($urandom) : ph_up[ph];
      write_reg(pap_pkg::CFG_PATH_BITS, 16'(ph_bits[ph]));
      write_reg(pap_pkg::CFG_MAX_PEN, 16'(ph_pen[ph]));
      write_reg(pap_pkg::CFG_UPPER, up);
      cfg_bus.valid <= 1'b0;
      if (ph < 3) begin
        tx_idle_pct = 8;
        rx_idle_pct = 58;
      end else if (ph < 6) begin
        tx_idle_pct = 58;
        rx_idle_pct = 8;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (ph == 6) hold_rx = 1'b1;
      for (int i = 0; i < PhaseBeats; i++) send_beat(rand_beat(), 1'b0, '0);
      in_bus.valid <= 1'b0;
    end

    for (int i = 0; i < 2000 && route_q.size() != 0; i++) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    if (route_q.size() != 0) flag_error($sformatf("%0d results never arrived", route_q.size()));

    $display("tb: %0d feedback and %0d request beats over %0d register settings",
             n_fb, n_req, NumPhases + 1);
    $display("tb: %0d results checked, %0d alternate picks, %0d rotation wraps",
             n_checked, n_alt, n_wrap);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/pap_pkg.sv
rtl/pap_if.sv
rtl/pap_ram.sv
rtl/penalty_aware_path_selector_top.sv
rtl/pap_chk.sv
bench/penalty_aware_path_selector_top_tb.sv
